>>> design/dfgw_pkg.sv
// ============================================================================
// dfgw_pkg
// Shared types and constants for the depth-first graph walk block.
// ============================================================================
package dfgw_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int STACK_DEPTH  = 1024;

  localparam int VTX_W   = 5;                        // vertex field width
  localparam int COUNT_W = 6;                        // vertex count register width
  localparam int ROW_W   = MAX_VERTICES;             // one adjacency row
  localparam int SA_W    = $clog2(STACK_DEPTH);      // stack address
  localparam int SP_W    = $clog2(STACK_DEPTH) + 1;  // stack pointer, holds the depth too

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(32);
  localparam logic [COUNT_W-1:0] VERTEX_LIMIT       = COUNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_WALK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_OK        = 2'd0,
    KIND_REJECT    = 2'd1,
    KIND_VISIT     = 2'd2,
    KIND_BAD_START = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_POP,
    S_CHECK,
    S_LOAD,
    S_PUSH
  } state_t;

  typedef struct packed {
    action_t          action;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } result_t;

endpackage

>>> design/dfgw_ram.sv
// ============================================================================
// dfgw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module dfgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/depth_first_graph_walk.sv
// Reject, clear and bad-start results come out in the cycle after the transfer; an accepted
// edge passes S_EDGE_A and S_EDGE_B (read-modify-write of two adjacency rows, one RAM read
// a cycle). Walk: a popped stack entry passes S_POP and S_CHECK, a visited vertex S_LOAD,
// then S_PUSH per pending neighbour; S_POP sees the stack empty. A visit result goes out
// once the next vertex is found, the final one with last. One item at a time; no stall on
// results. Reset (sync, active high) empties the graph via row valid bits, no clear pass.
// ============================================================================
// depth_first_graph_walk
// Adjacency bit matrix with add-edge, clear, and an explicit-stack depth-first walk.
// ============================================================================
module depth_first_graph_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dfgw_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          start,
  input  dfgw_pkg::item_t               item,
  output logic                          busy,
  output logic                          strobe,
  output dfgw_pkg::result_t             result
);

  dfgw_pkg::state_t state, state_next;

  logic [dfgw_pkg::COUNT_W-1:0] vertex_count;
  logic [dfgw_pkg::COUNT_W-1:0] live_n;
  logic [dfgw_pkg::ROW_W-1:0]   live_mask;

  logic [dfgw_pkg::VTX_W-1:0]   vtx_a, vtx_b;
  logic [dfgw_pkg::SP_W-1:0]    sp, sp_dec;
  logic [dfgw_pkg::ROW_W-1:0]   visited;
  logic [dfgw_pkg::ROW_W-1:0]   row_valid;
  logic                         row_valid_rd;
  logic [dfgw_pkg::ROW_W-1:0]   cand;
  logic [dfgw_pkg::VTX_W-1:0]   low_idx;
  logic [dfgw_pkg::VTX_W-1:0]   pend_vertex;
  logic                         pend_valid;

  // adjacency RAM port
  logic                         adj_we;
  logic [dfgw_pkg::VTX_W-1:0]   adj_waddr, adj_raddr;
  logic [dfgw_pkg::ROW_W-1:0]   adj_wdata, adj_rdata, row_now;

  // stack RAM port
  logic                         stk_we;
  logic [dfgw_pkg::SA_W-1:0]    stk_waddr, stk_raddr;
  logic [dfgw_pkg::VTX_W-1:0]   stk_wdata, stk_rdata;

  logic                         accept, a_ok, b_ok, skip;
  logic                         emit, emit_last;
  dfgw_pkg::kind_t              emit_kind;
  logic [dfgw_pkg::VTX_W-1:0]   emit_vertex;

  dfgw_ram #(.WIDTH(dfgw_pkg::ROW_W), .DEPTH(dfgw_pkg::MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfgw_ram #(.WIDTH(dfgw_pkg::VTX_W), .DEPTH(dfgw_pkg::STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // live vertex count and its mask
  always_comb begin
    live_n = (vertex_count > dfgw_pkg::VERTEX_LIMIT) ? dfgw_pkg::VERTEX_LIMIT : vertex_count;
    for (int i = 0; i < dfgw_pkg::ROW_W; i++) begin
      live_mask[i] = (dfgw_pkg::COUNT_W'(i) < live_n);
    end
  end

  // lowest pending neighbour goes on the stack first
  always_comb begin
    low_idx = '0;
    for (int i = dfgw_pkg::ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        low_idx = dfgw_pkg::VTX_W'(i);
      end
    end
  end

  assign busy    = (state != dfgw_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign a_ok    = ({1'b0, item.vertex_a} < live_n);
  assign b_ok    = ({1'b0, item.vertex_b} < live_n);
  assign sp_dec  = sp - dfgw_pkg::SP_W'(1);
  assign row_now = row_valid_rd ? adj_rdata : '0;
  assign skip    = ({1'b0, stk_rdata} >= live_n) || visited[stk_rdata];

  // next state, RAM control and result issue
  always_comb begin
    state_next  = state;
    adj_we      = 1'b0;
    adj_waddr   = vtx_a;
    adj_wdata   = row_now | (dfgw_pkg::ROW_W'(1) << vtx_b);
    adj_raddr   = vtx_a;
    stk_we      = 1'b0;
    stk_waddr   = sp[dfgw_pkg::SA_W-1:0];
    stk_wdata   = low_idx;
    stk_raddr   = sp_dec[dfgw_pkg::SA_W-1:0];
    emit        = 1'b0;
    emit_kind   = dfgw_pkg::KIND_OK;
    emit_vertex = '0;
    emit_last   = 1'b1;
    unique case (state)
      dfgw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.action)
            dfgw_pkg::ACT_ADD: begin
              if (a_ok && b_ok) begin
                adj_raddr  = item.vertex_a;
                state_next = dfgw_pkg::S_EDGE_A;
              end else begin
                emit      = 1'b1;
                emit_kind = dfgw_pkg::KIND_REJECT;
              end
            end
            dfgw_pkg::ACT_WALK: begin
              if (a_ok) begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = item.vertex_a;
                state_next = dfgw_pkg::S_POP;
              end else begin
                emit      = 1'b1;
                emit_kind = dfgw_pkg::KIND_BAD_START;
              end
            end
            dfgw_pkg::ACT_CLEAR: begin
              emit = 1'b1;
            end
            dfgw_pkg::ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      dfgw_pkg::S_EDGE_A: begin
        adj_we     = 1'b1;
        adj_raddr  = vtx_b;
        state_next = dfgw_pkg::S_EDGE_B;
      end
      dfgw_pkg::S_EDGE_B: begin
        // same row twice (self loop) writes the same value, so stale data is harmless
        adj_we     = 1'b1;
        adj_waddr  = vtx_b;
        adj_wdata  = row_now | (dfgw_pkg::ROW_W'(1) << vtx_a);
        emit       = 1'b1;
        state_next = dfgw_pkg::S_IDLE;
      end
      dfgw_pkg::S_POP: begin
        if (sp == '0) begin
          emit        = 1'b1;
          emit_kind   = dfgw_pkg::KIND_VISIT;
          emit_vertex = pend_vertex;
          state_next  = dfgw_pkg::S_IDLE;
        end else begin
          state_next = dfgw_pkg::S_CHECK;
        end
      end
      dfgw_pkg::S_CHECK: begin
        if (skip) begin
          state_next = dfgw_pkg::S_POP;
        end else begin
          adj_raddr   = stk_rdata;
          emit        = pend_valid;
          emit_kind   = dfgw_pkg::KIND_VISIT;
          emit_vertex = pend_vertex;
          emit_last   = 1'b0;
          state_next  = dfgw_pkg::S_LOAD;
        end
      end
      dfgw_pkg::S_LOAD: begin
        state_next = dfgw_pkg::S_PUSH;
      end
      dfgw_pkg::S_PUSH: begin
        if (cand == '0) begin
          state_next = dfgw_pkg::S_POP;
        end else begin
          stk_we = (sp < dfgw_pkg::SP_W'(dfgw_pkg::STACK_DEPTH));
        end
      end
      default: begin
        state_next = dfgw_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dfgw_pkg::S_IDLE;
      vertex_count <= dfgw_pkg::VERTEX_COUNT_RESET;
      sp           <= '0;
      visited      <= '0;
      row_valid    <= '0;
      pend_valid   <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      unique case (state)
        dfgw_pkg::S_IDLE: begin
          if (accept && item.action == dfgw_pkg::ACT_WALK && a_ok) begin
            visited    <= '0;
            sp         <= dfgw_pkg::SP_W'(1);
            pend_valid <= 1'b0;
          end
          if (accept && item.action == dfgw_pkg::ACT_CLEAR) begin
            row_valid <= '0;
          end
        end
        dfgw_pkg::S_EDGE_A: row_valid[vtx_a] <= 1'b1;
        dfgw_pkg::S_EDGE_B: row_valid[vtx_b] <= 1'b1;
        dfgw_pkg::S_POP: begin
          if (sp != '0) begin
            sp <= sp_dec;
          end
        end
        dfgw_pkg::S_CHECK: begin
          if (!skip) begin
            visited[stk_rdata] <= 1'b1;
            pend_valid         <= 1'b1;
          end
        end
        dfgw_pkg::S_LOAD: begin
        end
        dfgw_pkg::S_PUSH: begin
          if (stk_we) begin
            sp <= sp + dfgw_pkg::SP_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    row_valid_rd <= row_valid[adj_raddr];
    if (accept) begin
      vtx_a <= item.vertex_a;
      vtx_b <= item.vertex_b;
    end
    if (state == dfgw_pkg::S_CHECK && !skip) begin
      pend_vertex <= stk_rdata;
    end
    if (state == dfgw_pkg::S_LOAD) begin
      cand <= row_now & ~visited & live_mask;
    end else if (state == dfgw_pkg::S_PUSH && cand != '0) begin
      cand[low_idx] <= 1'b0;
    end
    if (emit) begin
      result.kind   <= emit_kind;
      result.vertex <= emit_vertex;
      result.last   <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // only walk visits may be non-final
  a_nonvisit_last: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.last || result.kind == dfgw_pkg::KIND_VISIT))
    else $error("non-visit result without last");

  // stack pointer stays within the stack
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= dfgw_pkg::SP_W'(dfgw_pkg::STACK_DEPTH))
    else $error("stack pointer overrun");

  // an empty stack ends the walk with a final visit result
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == dfgw_pkg::S_POP && sp == '0) |=>
      (strobe && result.last && result.kind == dfgw_pkg::KIND_VISIT && !busy))
    else $error("walk end without final result");

  // a good start seeds the stack with exactly one entry
  a_walk_seed: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == dfgw_pkg::ACT_WALK && a_ok) |=>
      (sp == dfgw_pkg::SP_W'(1) && visited == '0 && state == dfgw_pkg::S_POP))
    else $error("walk not seeded");
`endif

endmodule
